@@ rtl/core/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg: shared types and constants of the flanger delay unit
// Field widths, register indexes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifd_pkg;

    localparam int IFD_MAX_RING    = 4096;
    localparam int IFD_SAMPLE_BITS = 16;
    localparam int IFD_FRAC_BITS   = 8;

    localparam int RLEN_W    = 13;
    localparam int GAIN_W    = 16;
    localparam int DELAY_W   = 20;
    localparam int GAIN_FRAC = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [RLEN_W-1:0] RLEN_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 1'b1;

    typedef struct packed {
        logic clr;
        logic load;
        logic clamp;
        logic pos;
        logic rd;
        logic mul;
        logic sum;
        logic fbmul;
        logic wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

endpackage

@@ rtl/core/ifd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifd_ctrl: sequencer of the flanger delay unit
// Runs the clearing pass after reset, then steps each accepted word through
// the datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ifd_pkg::t_cmd    o_cmd,
    input  ifd_pkg::t_status i_status
);
    import ifd_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_POS   = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_FBMUL = 4'd7;
    localparam logic [3:0] S_WRITE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FBMUL;
            end
            S_FBMUL: begin
                o_cmd.fbmul = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                // hold here until the output register can take the word
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.wr) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CLAMP))
        else $error("accepted word did not start processing");

    a_valid_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("output valid rose outside the write step");

    a_clear_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("output valid during clearing pass");
`endif

endmodule

@@ rtl/core/ifd_datapath.sv @@
// ----------------------------------------------------------------------------
// ifd_datapath: ring memory and arithmetic of the flanger delay unit
// Read position, two-port ring read, linear interpolation, feedback
// multiply with saturation and the ring write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifd_datapath #(
    parameter int MAX_RING    = ifd_pkg::IFD_MAX_RING,
    parameter int SAMPLE_BITS = ifd_pkg::IFD_SAMPLE_BITS,
    parameter int FRAC_BITS   = ifd_pkg::IFD_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ifd_pkg::t_cmd                        i_cmd,
    output ifd_pkg::t_status                     o_status,
    input  logic [ifd_pkg::RLEN_W-1:0]           i_ring_length,
    input  logic signed [ifd_pkg::GAIN_W-1:0]    i_feedback_gain,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    input  logic [ifd_pkg::DELAY_W-1:0]          i_delay_amount,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out
);
    import ifd_pkg::*;

    localparam int AW = $clog2(MAX_RING);
    localparam int IW = (AW > RLEN_W) ? AW : RLEN_W;
    localparam int PW = (DELAY_W > IW + FRAC_BITS) ? DELAY_W : IW + FRAC_BITS;
    localparam int MW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int YW = MW + 1;
    localparam int FW = SAMPLE_BITS + GAIN_W;
    localparam int CW = FW + 2;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] mem [0:MAX_RING-1];

    logic [RLEN_W-1:0]             r_len;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [PW-1:0]                 r_dly;
    logic [AW-1:0]                 r_wp;
    logic [PW-1:0]                 r_rp;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS-1:0] r_b;
    logic signed [MW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [FW-1:0]          r_fprod;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic [AW-1:0]                 r_clr_cnt;

    logic [RLEN_W-1:0]             len_eff;
    logic [PW-1:0]                 limit;
    logic [PW-1:0]                 dly_clamped;
    logic [PW:0]                   pos_diff;
    logic [PW-1:0]                 rp_wrapped;
    logic [AW-1:0]                 rpi;
    logic [FRAC_BITS-1:0]          frac;
    logic [IW:0]                   rpi_inc;
    logic [AW-1:0]                 nxt;
    logic signed [SAMPLE_BITS:0]   d_ab;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [YW-1:0]          yacc;
    logic signed [YW-1:0]          yq;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [CW-1:0]          facc;
    logic signed [CW-1:0]          fq;
    logic signed [SAMPLE_BITS-1:0] acc_sat;
    logic [IW:0]                   wp_inc;
    logic [AW-1:0]                 wp_next;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;

    // ring length limited to [2, MAX_RING]
    always_comb begin
        if (i_ring_length < RLEN_W'(2)) begin
            len_eff = RLEN_W'(2);
        end else if (32'(i_ring_length) > 32'(MAX_RING)) begin
            len_eff = RLEN_W'(MAX_RING);
        end else begin
            len_eff = i_ring_length;
        end
    end

    assign limit       = PW'(r_len) << FRAC_BITS;
    assign dly_clamped = (r_dly > limit) ? limit : r_dly;

    // read position = write position - delay, wrapped once into the ring
    assign pos_diff   = {1'b0, PW'(r_wp) << FRAC_BITS} - {1'b0, r_dly};
    assign rp_wrapped = pos_diff[PW] ? (pos_diff[PW-1:0] + limit) : pos_diff[PW-1:0];

    assign rpi     = r_rp[FRAC_BITS +: AW];
    assign frac    = r_rp[FRAC_BITS-1:0];
    assign rpi_inc = (IW+1)'(rpi) + (IW+1)'(1);
    assign nxt     = (rpi_inc < (IW+1)'(r_len)) ? rpi_inc[AW-1:0] : '0;

    assign d_ab   = {r_b[SAMPLE_BITS-1], r_b} - {r_a[SAMPLE_BITS-1], r_a};
    assign frac_s = $signed({1'b0, frac});

    // a + round(frac * (b - a)) folded into one shifted sum
    always_comb begin
        yacc = (YW'(r_a) <<< FRAC_BITS) + YW'(r_prod) + (YW'(1) <<< (FRAC_BITS - 1));
        yq   = yacc >>> FRAC_BITS;
        if (yq > YW'(S_MAX)) begin
            y_sat = S_MAX;
        end else if (yq < YW'(S_MIN)) begin
            y_sat = S_MIN;
        end else begin
            y_sat = yq[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        facc = (CW'(r_x) <<< GAIN_FRAC) + CW'(r_fprod) + (CW'(1) <<< (GAIN_FRAC - 1));
        fq   = facc >>> GAIN_FRAC;
        if (fq > CW'(S_MAX)) begin
            acc_sat = S_MAX;
        end else if (fq < CW'(S_MIN)) begin
            acc_sat = S_MIN;
        end else begin
            acc_sat = fq[SAMPLE_BITS-1:0];
        end
    end

    assign wp_inc  = (IW+1)'(r_wp) + (IW+1)'(1);
    assign wp_next = (wp_inc < (IW+1)'(r_len)) ? wp_inc[AW-1:0] : '0;

    assign mem_we    = i_cmd.clr | i_cmd.wr;
    assign mem_waddr = i_cmd.clr ? r_clr_cnt : r_wp;
    assign mem_wdata = i_cmd.clr ? '0 : acc_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_a <= mem[rpi];
            r_b <= mem[nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            // a write index left beyond a shortened ring restarts at zero
            if (i_cmd.clamp && (IW'(r_wp) >= IW'(r_len))) begin
                r_wp <= '0;
            end else if (i_cmd.wr) begin
                r_wp <= wp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len <= len_eff;
            r_x   <= i_sample_in;
            r_dly <= PW'(i_delay_amount);
        end
        if (i_cmd.clamp) begin
            r_dly <= dly_clamped;
        end
        if (i_cmd.pos) begin
            r_rp <= rp_wrapped;
        end
        if (i_cmd.mul) begin
            r_prod <= MW'(d_ab) * MW'(frac_s);
        end
        if (i_cmd.sum) begin
            r_y <= y_sat;
        end
        if (i_cmd.fbmul) begin
            r_fprod <= FW'(r_y) * FW'(i_feedback_gain);
        end
        if (i_cmd.wr) begin
            r_out <= r_y;
        end
    end

    assign o_status.clr_last = (r_clr_cnt == AW'(MAX_RING - 1));
    assign o_sample_out      = r_out;

`ifndef NO_ASSERTIONS
    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pos |-> (IW'(r_wp) < IW'(r_len)))
        else $error("write index outside ring");

    a_rp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_rp < limit))
        else $error("read position outside ring");

    a_interp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> ((r_y >= r_a && r_y <= r_b) || (r_y <= r_a && r_y >= r_b)))
        else $error("interpolated sample outside its neighbors");
`endif

endmodule

@@ rtl/core/interpolating_flanger_delay_unit.sv @@
// ----------------------------------------------------------------------------
// interpolating_flanger_delay_unit: variable delay with linear interpolation
// Each accepted word is stepped through clamp, position, ring read, two
// multiplies, sum and the ring write; a new word is taken only after the
// last is written, and the write step holds while a stalled word is held.
// Reset: all MAX_RING ring entries (4096 by default) are cleared by a pass
// with the input stalled; config writes are taken during the pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interpolating_flanger_delay_unit #(
    parameter int MAX_RING    = ifd_pkg::IFD_MAX_RING,
    parameter int SAMPLE_BITS = ifd_pkg::IFD_SAMPLE_BITS,
    parameter int FRAC_BITS   = ifd_pkg::IFD_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  logic [ifd_pkg::DELAY_W-1:0]       i_delay_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    input  logic                              i_cfg_we,
    input  logic [ifd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ifd_pkg::CFG_W-1:0]         i_cfg_data
);
    import ifd_pkg::*;

    logic [RLEN_W-1:0]        r_ring_length;
    logic signed [GAIN_W-1:0] r_feedback_gain;
    t_cmd                     cmd;
    t_status                  status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length   <= RLEN_RESET;
            r_feedback_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RING_LENGTH: begin
                    r_ring_length <= i_cfg_data[RLEN_W-1:0];
                end
                CFG_FEEDBACK_GAIN: begin
                    r_feedback_gain <= $signed(i_cfg_data[GAIN_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    ifd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    ifd_datapath #(
        .MAX_RING    (MAX_RING),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_ring_length   (r_ring_length),
        .i_feedback_gain (r_feedback_gain),
        .i_sample_in     (i_sample_in),
        .i_delay_amount  (i_delay_amount),
        .o_sample_out    (o_sample_out)
    );

endmodule

@@ tb/tb_interpolating_flanger_delay_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interpolating_flanger_delay_unit: self-checking bench of the flanger tap
// Drives sample/delay words with random gaps and output stalls, predicts each
// interpolated tap from a software copy of the ring and the feedback path, and
// compares every output word in order. Ring length and feedback gain are
// changed between phases while the unit is idle.
// ----------------------------------------------------------------------------

module tb_interpolating_flanger_delay_unit;
    import ifd_pkg::*;

    localparam int     HOLD_CYCLES = 300;
    localparam int     IDLE_PAUSE  = 20;
    localparam int     CYCLE_LIMIT = 1500000;
    localparam int     REPORT_MAX  = 10;
    localparam int     RAND_PHASES = 13;
    localparam int     PHASE_WORDS = 150;
    localparam longint SMP_MAX     = (64'sd1 <<< (IFD_SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN     = -SMP_MAX - 1;

    typedef struct {
        logic signed [IFD_SAMPLE_BITS-1:0] smp;
        logic [DELAY_W-1:0]                dly;
    } t_voice_word;

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_in_valid     = 1'b0;
    logic                              o_in_stall;
    logic signed [IFD_SAMPLE_BITS-1:0] i_sample_in    = '0;
    logic [DELAY_W-1:0]                i_delay_amount = '0;
    logic                              o_out_valid;
    logic                              i_out_stall    = 1'b0;
    logic signed [IFD_SAMPLE_BITS-1:0] o_sample_out;
    logic                              i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]              i_cfg_index    = CFG_RING_LENGTH;
    logic [CFG_W-1:0]                  i_cfg_data     = '0;

    // software copy of the unit's state and registers
    logic signed [IFD_SAMPLE_BITS-1:0] tap_ring [0:IFD_MAX_RING-1];
    int                                tap_wr;
    logic [RLEN_W-1:0]                 tap_len;
    logic signed [GAIN_W-1:0]          tap_gain;

    t_voice_word                       pending_words[$];
    logic signed [IFD_SAMPLE_BITS-1:0] tap_expected[$];
    t_voice_word                       drv_word;

    logic   in_taken        = 1'b0;
    int     words_issued    = 0;
    int     words_taken     = 0;
    int     gap_left        = 0;
    int     seg_left        = 0;
    int     hold_left       = 0;
    bit     sender_idles    = 1'b1;
    bit     receiver_stalls = 1'b1;
    int     fail_count      = 0;
    longint cycle_count     = 0;

    interpolating_flanger_delay_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .i_delay_amount (i_delay_amount),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic longint clip(input longint v);
        if (v > SMP_MAX) return SMP_MAX;
        if (v < SMP_MIN) return SMP_MIN;
        return v;
    endfunction

    // interpolated tap for one word, then the feedback write and pointer step
    function automatic logic signed [IFD_SAMPLE_BITS-1:0] flanger_tap(
        input logic signed [IFD_SAMPLE_BITS-1:0] x_in,
        input logic [DELAY_W-1:0]                dly_in
    );
        longint span, wp, dly, lim, rp, rpi, nxt, frac, a, b, y, g, fb;
        span = tap_len;
        if (span < 2) span = 2;
        if (span > IFD_MAX_RING) span = IFD_MAX_RING;
        wp = tap_wr;
        if (wp >= span) wp = 0;
        dly = dly_in;
        lim = span <<< IFD_FRAC_BITS;
        if (dly > lim) dly = lim;
        rp = (wp <<< IFD_FRAC_BITS) - dly;
        if (rp < 0) rp = rp + lim;
        if (rp >= lim) rp = rp - lim;
        rpi = rp >>> IFD_FRAC_BITS;
        if (rpi >= span) rpi = 0;
        frac = rp & ((64'sd1 <<< IFD_FRAC_BITS) - 1);
        nxt = (rpi + 1 < span) ? rpi + 1 : 0;
        a = tap_ring[rpi];
        b = tap_ring[nxt];
        y = clip(a + ((frac * (b - a) + (64'sd1 <<< (IFD_FRAC_BITS - 1))) >>> IFD_FRAC_BITS));
        g = tap_gain;
        fb = (y * g + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        tap_ring[wp] = IFD_SAMPLE_BITS'(clip(x_in + fb));
        tap_wr = (wp + 1 < span) ? int'(wp + 1) : 0;
        return IFD_SAMPLE_BITS'(y);
    endfunction

    task automatic log_fail(input string what, input logic [IFD_SAMPLE_BITS-1:0] want,
                            input logic [IFD_SAMPLE_BITS-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    function automatic void push_word(input logic [IFD_SAMPLE_BITS-1:0] s,
                                      input logic [DELAY_W-1:0] d);
        t_voice_word w;
        w.smp = s;
        w.dly = d;
        pending_words.push_back(w);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RING_LENGTH:   tap_len  = val[RLEN_W-1:0];
            CFG_FEEDBACK_GAIN: tap_gain = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || words_issued != words_taken ||
               tap_expected.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_PAUSE) @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [RLEN_W-1:0] len, input logic [GAIN_W-1:0] gain);
        logic [CFG_W-1:0] v;
        wait_idle();
        // unused upper bits of the length register get random values
        v = CFG_W'($urandom);
        v[RLEN_W-1:0] = len;
        write_reg(CFG_RING_LENGTH, v);
        write_reg(CFG_FEEDBACK_GAIN, gain);
    endtask

    // sender: new word only once the held one is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_words.size() != 0) begin
                drv_word = pending_words.pop_front();
                words_issued++;
                i_in_valid     <= 1'b1;
                i_sample_in    <= drv_word.smp;
                i_delay_amount <= drv_word.dly;
                gap_left = (sender_idles && $urandom_range(0, 2) == 0) ? pick_len() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall segments, plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (seg_left > 0) begin
            seg_left = seg_left - 1;
        end else begin
            i_out_stall <= receiver_stalls && ($urandom_range(0, 3) == 0);
            seg_left = pick_len() - 1;
        end
    end

    always @(posedge i_clk) begin
        logic signed [IFD_SAMPLE_BITS-1:0] want;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tap_expected.push_back(flanger_tap(i_sample_in, i_delay_amount));
                words_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (tap_expected.size() == 0) begin
                    log_fail("output word with nothing expected", '0, o_sample_out);
                end else begin
                    want = tap_expected.pop_front();
                    if (o_sample_out !== want)
                        log_fail("sample_out mismatch", want, o_sample_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int                        eff, r;
        logic [RLEN_W-1:0]         len_pick;
        logic [GAIN_W-1:0]         gain_pick;
        logic [DELAY_W-1:0]        dly_pick;
        logic [IFD_SAMPLE_BITS-1:0] smp_pick;

        for (int k = 0; k < IFD_MAX_RING; k++) tap_ring[k] = '0;
        tap_wr   = 0;
        tap_len  = RLEN_RESET;
        tap_gain = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short ring, no feedback: sample extremes, fractions, delay clamp
        reconfigure(13'd8, 16'h0000);
        push_word(16'h7FFF, 20'h00000);
        push_word(16'h8000, 20'h00000);
        push_word(16'h0001, 20'h00001);
        push_word(16'hFFFF, 20'h000FF);
        push_word(16'h1234, 20'h00180);
        push_word(16'h0000, 20'h00800);
        push_word(16'h4321, 20'hFFFFF);
        push_word(16'h7FFF, 20'h00801);
        push_word(16'h8000, 20'h007FF);
        push_word(16'h0000, 20'h00080);
        push_word(16'hABCD, 20'h003C0);
        push_word(16'h5555, 20'h00201);

        // ring shrinks under the write pointer; full positive gain saturates
        reconfigure(13'd3, 16'h7FFF);
        push_word(16'h7FFF, 20'h00300);
        push_word(16'h7FFF, 20'h00300);
        push_word(16'h7FFF, 20'h00300);
        push_word(16'h7FFF, 20'h00100);

        // length below the minimum, gain of minus one
        reconfigure(13'd0, 16'h8000);
        push_word(16'h8000, 20'h00200);
        push_word(16'h8000, 20'h00200);
        push_word(16'h7FFF, 20'h00000);
        push_word(16'h8000, 20'h001FF);

        // length above the maximum
        reconfigure(13'h1FFF, 16'h4000);
        push_word(16'h7FFF, 20'hFFFFF);
        push_word(16'h8000, 20'h00000);
        push_word(16'h2468, 20'hFFFFF);

        for (int p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(0, 9);
            if (p == 0)      len_pick = 13'd4096;
            else if (p == 1) len_pick = 13'd2;
            else if (r == 0) len_pick = RLEN_W'($urandom_range(0, 1));
            else if (r == 1) len_pick = 13'd4096;
            else if (r == 2) len_pick = RLEN_W'($urandom_range(4097, 8191));
            else if (r == 9) len_pick = RLEN_W'($urandom_range(41, 4096));
            else             len_pick = RLEN_W'($urandom_range(2, 40));

            r = $urandom_range(0, 5);
            if (r == 0)      gain_pick = 16'h0000;
            else if (r == 1) gain_pick = 16'h7FFF;
            else if (r == 2) gain_pick = 16'h8000;
            else             gain_pick = GAIN_W'($urandom);

            reconfigure(len_pick, gain_pick);
            eff = (len_pick < 2) ? 2 : (len_pick > IFD_MAX_RING) ? IFD_MAX_RING : len_pick;

            // phase 1 backs up the unit, phase 2 runs flat out
            sender_idles    = (p != 1 && p != 2);
            receiver_stalls = (p != 2);
            if (p == 1) hold_left = HOLD_CYCLES;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(0, 7);
                if (r == 0)      smp_pick = 16'h7FFF;
                else if (r == 1) smp_pick = 16'h8000;
                else             smp_pick = IFD_SAMPLE_BITS'($urandom);

                r = $urandom_range(0, 9);
                if (r == 0)      dly_pick = DELAY_W'($urandom);
                else if (r == 1) dly_pick = (eff * 256 > 20'hFFFFF) ? 20'hFFFFF
                                                                     : DELAY_W'(eff * 256);
                else if (r == 2) dly_pick = DELAY_W'($urandom_range(0, 255));
                else             dly_pick = DELAY_W'($urandom_range(0, eff * 256 - 1));
                push_word(smp_pick, dly_pick);
            end
        end

        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        wait_idle();

        if (fail_count == 0 && tap_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
